/* rtl/core/ncdf_pkg.sv */
// shared types, constants and arithmetic helpers for the normal cdf unit
package ncdf_pkg;

    // fixed-point formats
    localparam int FRAC_BITS = 16;
    localparam int QB        = 30;
    localparam int X_W       = FRAC_BITS + 4;
    localparam int CDF_W     = FRAC_BITS + 1;
    localparam int PDF_W     = FRAC_BITS - 1;
    localparam int OUT_SH    = QB - FRAC_BITS;
    localparam int XQ_W      = QB + 4;
    localparam int XS_W      = XQ_W - 2;
    localparam int SQ_W      = 2 * XS_W;
    localparam int U_SH      = 2 * (QB - 2) - QB + 1;
    localparam int U_W       = QB + 6;
    localparam int N_W       = U_W - QB;
    localparam int P_W       = 28;
    localparam int PM_W      = P_W + X_W;
    localparam int DEN_W     = 32;
    localparam int POLY_W    = 34;
    localparam int MAG_W     = POLY_W - 1;
    localparam int PHI_W     = 29;
    localparam int V_W       = QB;
    localparam int RECIP_SH  = 35;
    localparam int RECIP_W   = RECIP_SH + 1;
    localparam int PROD_W    = V_W + RECIP_W;

    // pipeline geometry
    localparam int DIV_STAGES   = QB + 1;
    localparam int POLY_STAGES  = 5;
    localparam int POLY_LAT     = DIV_STAGES + POLY_STAGES;
    localparam int EXP_TERMS    = 16;
    localparam int POW_STAGES   = 32;
    localparam int PHI_LAT      = 3 * EXP_TERMS + POW_STAGES + 1;
    localparam int ALIGN_STAGES = PHI_LAT - POLY_LAT;
    localparam int LATENCY      = PHI_LAT + 4;

    typedef logic [QB:0]               qval_t;
    typedef logic signed [POLY_W-1:0]  spoly_t;
    typedef logic [DEN_W-1:0]          den_t;

    localparam logic [63:0] Q_ONE     = 64'd1 << QB;
    localparam logic [63:0] Q_HALF    = 64'd1 << (QB - 1);
    localparam logic [63:0] DEC_SCALE = 64'd1000000000;

    localparam logic [63:0] COEF_P  = (64'd231641900 * Q_ONE + DEC_SCALE / 2) / DEC_SCALE;
    localparam logic [63:0] COEF_B1 = (64'd319381530 * Q_ONE + DEC_SCALE / 2) / DEC_SCALE;
    localparam logic [63:0] COEF_B2 = (64'd356563782 * Q_ONE + DEC_SCALE / 2) / DEC_SCALE;
    localparam logic [63:0] COEF_B3 = (64'd1781477937 * Q_ONE + DEC_SCALE / 2) / DEC_SCALE;
    localparam logic [63:0] COEF_B4 = (64'd1821255978 * Q_ONE + DEC_SCALE / 2) / DEC_SCALE;
    localparam logic [63:0] COEF_B5 = (64'd1330274429 * Q_ONE + DEC_SCALE / 2) / DEC_SCALE;
    localparam logic [63:0] INV_SQRT_2PI =
        (64'd3989422804 * Q_ONE + 64'd5000000000) / 64'd10000000000;

    // exp(-1) from the same 16-term horner form at f = 1.0
    localparam logic [63:0] EXP_M1 = 64'd395007542;

    localparam spoly_t POLY_B1 = spoly_t'(COEF_B1);
    localparam spoly_t POLY_B2 = -spoly_t'(COEF_B2);
    localparam spoly_t POLY_B3 = spoly_t'(COEF_B3);
    localparam spoly_t POLY_B4 = -spoly_t'(COEF_B4);
    localparam spoly_t POLY_B5 = spoly_t'(COEF_B5);

    localparam logic [63:0] ROUND_HALF = (OUT_SH == 0) ? 64'd0 : (64'd1 << (OUT_SH - 1));
    localparam logic [63:0] PDF_MAX    = (INV_SQRT_2PI + ROUND_HALF) >> OUT_SH;
    localparam logic [63:0] CDF_ONE    = 64'd1 << FRAC_BITS;

    // q30 product back to q30, round to nearest
    function automatic logic [63:0] rnd_q(input logic [63:0] prod);
        return (prod + Q_HALF) >> QB;
    endfunction

    // signed by unsigned q30 product, rounded on the magnitude
    function automatic spoly_t mul_sgn(input spoly_t a, input qval_t b);
        logic             neg;
        logic [MAG_W-1:0] mag;
        logic [63:0]      prod;
        neg  = a[POLY_W-1];
        mag  = neg ? MAG_W'(-a) : MAG_W'(a);
        prod = rnd_q(64'(mag) * 64'(b));
        return neg ? -spoly_t'(prod) : spoly_t'(prod);
    endfunction

    // horner constant added after each product, lowest order last
    function automatic spoly_t horner_coef(input int idx);
        spoly_t c;
        unique case (idx)
            0:       c = POLY_B4;
            1:       c = POLY_B3;
            2:       c = POLY_B2;
            3:       c = POLY_B1;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

/* rtl/core/ncdf_div.sv */
// pipelined restoring divider for t = 2^60 / den, one quotient bit per stage
module ncdf_div (
    input  logic           clk,
    input  logic           en,
    input  ncdf_pkg::den_t den,
    output ncdf_pkg::qval_t quot
);
    import ncdf_pkg::*;

    localparam int REM_W = DEN_W + 1;

    den_t             den_reg  [DIV_STAGES];
    logic [DEN_W-1:0] rem_reg  [DIV_STAGES];
    qval_t            quot_reg [DIV_STAGES];

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_step
        localparam int BIT = DIV_STAGES - 1 - g;
        den_t             d_cur;
        logic [DEN_W-1:0] r_cur;
        qval_t            q_cur;
        logic [REM_W-1:0] trial;
        logic [DEN_W-1:0] rem_next;
        qval_t            quot_next;

        if (g == 0) begin : g_first
            // numerator top bits are exactly 2^(QB-1), rounding half lives in low bits
            assign d_cur = den;
            assign r_cur = DEN_W'(1) << (QB - 1);
            assign q_cur = '0;
        end
        else begin : g_rest
            assign d_cur = den_reg[g-1];
            assign r_cur = rem_reg[g-1];
            assign q_cur = quot_reg[g-1];
        end

        always_comb
        begin
            // low numerator bit i equals bit i+1 of den (the den/2 rounding term)
            trial     = {r_cur, d_cur[BIT+1]};
            quot_next = q_cur;
            if (trial >= {1'b0, d_cur})
            begin
                rem_next       = DEN_W'(trial - {1'b0, d_cur});
                quot_next[BIT] = 1'b1;
            end
            else
            begin
                rem_next = trial[DEN_W-1:0];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                den_reg[g]  <= d_cur;
                rem_reg[g]  <= rem_next;
                quot_reg[g] <= quot_next;
            end
        end
    end

    assign quot = quot_reg[DIV_STAGES-1];

endmodule

/* rtl/core/ncdf_poly.sv */
// five-stage horner evaluation of the b1..b5 polynomial in t
module ncdf_poly (
    input  logic             clk,
    input  logic             en,
    input  ncdf_pkg::qval_t  t_in,
    output ncdf_pkg::spoly_t poly
);
    import ncdf_pkg::*;

    qval_t  t_reg   [POLY_STAGES];
    spoly_t acc_reg [POLY_STAGES];

    for (genvar g = 0; g < POLY_STAGES; g++) begin : g_step
        qval_t  t_cur;
        spoly_t acc_cur;
        spoly_t acc_next;

        if (g == 0) begin : g_first
            assign t_cur   = t_in;
            assign acc_cur = POLY_B5;
        end
        else begin : g_rest
            assign t_cur   = t_reg[g-1];
            assign acc_cur = acc_reg[g-1];
        end

        assign acc_next = mul_sgn(acc_cur, t_cur) + horner_coef(g);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                t_reg[g]   <= t_cur;
                acc_reg[g] <= acc_next;
            end
        end
    end

    assign poly = acc_reg[POLY_STAGES-1];

endmodule

/* rtl/core/ncdf_exp.sv */
// density path: exp(-f) horner steps, exp(-1) powers, scale by 1/sqrt(2 pi)
module ncdf_exp (
    input  logic                         clk,
    input  logic                         en,
    input  logic [ncdf_pkg::QB-1:0]      frac,
    input  logic [ncdf_pkg::N_W-1:0]     whole,
    output logic [ncdf_pkg::PHI_W-1:0]   phi
);
    import ncdf_pkg::*;

    localparam int QK_W = QB + 6;

    // three stages per horner term: product, reciprocal product, correction
    logic [QB-1:0]     a_f_reg  [EXP_TERMS];
    logic [N_W-1:0]    a_n_reg  [EXP_TERMS];
    logic [V_W-1:0]    a_v_reg  [EXP_TERMS];
    logic [QB-1:0]     b_f_reg  [EXP_TERMS];
    logic [N_W-1:0]    b_n_reg  [EXP_TERMS];
    logic [V_W-1:0]    b_v_reg  [EXP_TERMS];
    logic [PROD_W-1:0] b_p_reg  [EXP_TERMS];
    logic [QB-1:0]     c_f_reg  [EXP_TERMS];
    logic [N_W-1:0]    c_n_reg  [EXP_TERMS];
    qval_t             c_s_reg  [EXP_TERMS];
    qval_t             pw_e_reg [POW_STAGES];
    logic [N_W-1:0]    pw_n_reg [POW_STAGES];
    logic [PHI_W-1:0]  phi_reg;

    for (genvar j = 0; j < EXP_TERMS; j++) begin : g_term
        localparam int K = EXP_TERMS - j;
        localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SH) / 64'(K));

        logic [QB-1:0]     f_cur;
        logic [N_W-1:0]    n_cur;
        qval_t             s_cur;
        logic [V_W-1:0]    a_v_next;
        logic [PROD_W-1:0] b_p_next;
        qval_t             q_est;
        logic [QK_W-1:0]   qk;
        logic [V_W:0]      rem;
        qval_t             q_fix;
        qval_t             c_s_next;

        if (j == 0) begin : g_first
            assign f_cur = frac;
            assign n_cur = whole;
            assign s_cur = qval_t'(Q_ONE);
        end
        else begin : g_rest
            assign f_cur = c_f_reg[j-1];
            assign n_cur = c_n_reg[j-1];
            assign s_cur = c_s_reg[j-1];
        end

        assign a_v_next = V_W'(rnd_q(64'(f_cur) * 64'(s_cur)));
        assign b_p_next = PROD_W'(a_v_reg[j]) * PROD_W'(RECIP);

        always_comb
        begin
            // reciprocal estimate is exact or one low
            q_est = qval_t'(b_p_reg[j] >> RECIP_SH);
            qk    = QK_W'(q_est) * QK_W'(K);
            rem   = (V_W + 1)'(b_v_reg[j]) - (V_W + 1)'(qk);
            q_fix = (rem >= (V_W + 1)'(K)) ? q_est + qval_t'(1) : q_est;
            c_s_next = qval_t'(Q_ONE) - q_fix;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                a_f_reg[j] <= f_cur;
                a_n_reg[j] <= n_cur;
                a_v_reg[j] <= a_v_next;
                b_f_reg[j] <= a_f_reg[j];
                b_n_reg[j] <= a_n_reg[j];
                b_v_reg[j] <= a_v_reg[j];
                b_p_reg[j] <= b_p_next;
                c_f_reg[j] <= b_f_reg[j];
                c_n_reg[j] <= b_n_reg[j];
                c_s_reg[j] <= c_s_next;
            end
        end
    end

    // one conditional multiply by exp(-1) per stage, for the integer part
    for (genvar i = 0; i < POW_STAGES; i++) begin : g_pow
        qval_t          e_cur;
        logic [N_W-1:0] n_cur;
        qval_t          e_next;

        if (i == 0) begin : g_first
            assign e_cur = c_s_reg[EXP_TERMS-1];
            assign n_cur = c_n_reg[EXP_TERMS-1];
        end
        else begin : g_rest
            assign e_cur = pw_e_reg[i-1];
            assign n_cur = pw_n_reg[i-1];
        end

        assign e_next = (n_cur > N_W'(i)) ? qval_t'(rnd_q(64'(e_cur) * EXP_M1)) : e_cur;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pw_e_reg[i] <= e_next;
                pw_n_reg[i] <= n_cur;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            phi_reg <= PHI_W'(rnd_q(64'(pw_e_reg[POW_STAGES-1]) * INV_SQRT_2PI));
        end
    end

    assign phi = phi_reg;

endmodule

/* rtl/core/normal_cdf_approximation_unit.sv */
// top level of the streaming standard normal cdf and density evaluator
//
// input channel: in_valid / in_ready with x_value, a signed q3.16 argument
// output channel: out_valid / out_ready with cdf_value (unsigned q1.16, 0..1.0
// saturated) and density_value (unsigned q0.16 density at |x|)
// one result beat leaves for every input beat, in order
// the density path is the longest: 48 stages of exp(-f) horner terms,
// 32 stages of exp(-1) powers and one scale stage, between two front stages
// (magnitude, products) and two back stages (poly times density, output reg)
// the t = 1/(1+px) divider (31 stages) and polynomial (5 stages) run beside
// it and are delayed to line up
// throughput: one beat per cycle while out_ready stays high
// stall: when the output register holds a beat that is not taken, the whole
// pipeline freezes and in_ready drops; nothing is lost or repeated
// reset: rst_n clears all valid bits, so no result beat is shown after reset
module normal_cdf_approximation_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [ncdf_pkg::X_W-1:0]   x_value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [ncdf_pkg::CDF_W-1:0]        cdf_value,
    output logic [ncdf_pkg::PDF_W-1:0]        density_value
);
    import ncdf_pkg::*;

    // global advance: the pipe moves whenever the output slot can take a beat
    logic en;

    // valid bit for every stage, last one is the output register
    logic [LATENCY-1:0] vld_reg;
    logic [LATENCY-1:0] vld_next;

    // stage 1: sign, magnitude, square and p*|x| products
    logic             neg_cur;
    logic [X_W-1:0]   mag;
    logic [XQ_W-1:0]  xq;
    logic [XS_W-1:0]  xs;
    logic             neg_s1_reg;
    logic [SQ_W-1:0]  sq_s1_reg;
    logic [PM_W-1:0]  pm_s1_reg;

    // stage 2: divisor, integer and fraction of x^2/2
    logic [PM_W-1:0]  px_sum;
    den_t             den_next;
    logic [U_W-1:0]   u_val;
    logic             neg_s2_reg;
    den_t             den_s2_reg;
    logic [N_W-1:0]   n_s2_reg;
    logic [QB-1:0]    f_s2_reg;

    // parallel paths
    qval_t            t_val;
    spoly_t           poly_val;
    logic [PHI_W-1:0] phi_val;
    spoly_t           poly_dly_reg [ALIGN_STAGES];
    logic             neg_dly_reg  [PHI_LAT];

    // stage m: poly times density
    spoly_t           pp_m_reg;
    logic [PHI_W-1:0] phi_m_reg;
    logic             neg_m_reg;

    // output register
    logic signed [POLY_W:0] c_full;
    qval_t                  c_clamp;
    qval_t                  cdf_q;
    logic [63:0]            cdf_round;
    logic [CDF_W-1:0]       cdf_next;
    logic [PDF_W-1:0]       density_next;
    logic [CDF_W-1:0]       cdf_reg;
    logic [PDF_W-1:0]       density_reg;

    assign en       = !vld_reg[LATENCY-1] || out_ready;
    assign in_ready = en;
    assign vld_next = {vld_reg[LATENCY-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    // most negative argument negates to exactly 8.0 in the unsigned view
    assign neg_cur = x_value[X_W-1];
    assign mag     = neg_cur ? X_W'(-x_value) : X_W'(x_value);
    assign xq      = XQ_W'(mag) << (QB - FRAC_BITS);
    assign xs      = xq[XQ_W-1:2];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_s1_reg <= neg_cur;
            sq_s1_reg  <= SQ_W'(xs) * SQ_W'(xs);
            pm_s1_reg  <= PM_W'(COEF_P[P_W-1:0]) * PM_W'(mag);
        end
    end

    // p*x rounded to q30 straight from the q.FRAC_BITS magnitude
    assign px_sum   = pm_s1_reg + (PM_W'(1) << (FRAC_BITS - 1));
    assign den_next = DEN_W'(Q_ONE) + DEN_W'(px_sum >> FRAC_BITS);
    assign u_val    = U_W'((sq_s1_reg + (SQ_W'(1) << (U_SH - 1))) >> U_SH);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_s2_reg <= neg_s1_reg;
            den_s2_reg <= den_next;
            n_s2_reg   <= u_val[U_W-1:QB];
            f_s2_reg   <= u_val[QB-1:0];
        end
    end

    ncdf_div u_div (
        .clk  (clk),
        .en   (en),
        .den  (den_s2_reg),
        .quot (t_val)
    );

    ncdf_poly u_poly (
        .clk  (clk),
        .en   (en),
        .t_in (t_val),
        .poly (poly_val)
    );

    ncdf_exp u_exp (
        .clk   (clk),
        .en    (en),
        .frac  (f_s2_reg),
        .whole (n_s2_reg),
        .phi   (phi_val)
    );

    // line the polynomial and the sign up with the density path
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            poly_dly_reg[0] <= poly_val;
            neg_dly_reg[0]  <= neg_s2_reg;
            for (int i = 1; i < ALIGN_STAGES; i++)
            begin
                poly_dly_reg[i] <= poly_dly_reg[i-1];
            end
            for (int i = 1; i < PHI_LAT; i++)
            begin
                neg_dly_reg[i] <= neg_dly_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp_m_reg  <= mul_sgn(poly_dly_reg[ALIGN_STAGES-1], qval_t'(phi_val));
            phi_m_reg <= phi_val;
            neg_m_reg <= neg_dly_reg[PHI_LAT-1];
        end
    end

    always_comb
    begin
        c_full = $signed({1'b0, Q_ONE[QB:0]}) - (POLY_W + 1)'(pp_m_reg);
        // polynomial overshoot saturates to 0 .. 1.0
        if (c_full < 0)
        begin
            c_clamp = '0;
        end
        else if (c_full > $signed({1'b0, Q_ONE[QB:0]}))
        begin
            c_clamp = qval_t'(Q_ONE);
        end
        else
        begin
            c_clamp = c_full[QB:0];
        end
        // negative argument by symmetry, before output rounding
        cdf_q     = neg_m_reg ? qval_t'(Q_ONE) - c_clamp : c_clamp;
        cdf_round = (64'(cdf_q) + ROUND_HALF) >> OUT_SH;
        if (cdf_round > CDF_ONE)
        begin
            cdf_round = CDF_ONE;
        end
        cdf_next     = CDF_W'(cdf_round);
        density_next = PDF_W'((64'(phi_m_reg) + ROUND_HALF) >> OUT_SH);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cdf_reg     <= cdf_next;
            density_reg <= density_next;
        end
    end

    assign out_valid     = vld_reg[LATENCY-1];
    assign cdf_value     = cdf_reg;
    assign density_value = density_reg;

    // result never exceeds 1.0
    a_cdf_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (64'(cdf_value) <= CDF_ONE))
        else $error("cdf beat above one");

    // density never exceeds its peak at zero
    a_pdf_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (64'(density_value) <= PDF_MAX))
        else $error("density beat above peak");

    // an accepted beat enters the first stage
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> vld_reg[0])
        else $error("accepted beat lost at entry");

    // a frozen pipe keeps every valid bit
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("valid bits moved during stall");

endmodule
